// ----- rtl/rlms_pkg.sv -----
// Package for the resample, interpolate and mix unit.
// Holds constants, command codes and shared types. No dependencies.
`timescale 1ns / 1ps
package rlms_pkg;
   localparam int SourceDepth = 4096;
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD = 2'd1;
   localparam logic [1:0] CMD_MIX = 2'd2;
   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam logic [1:0] REG_VOLUME = 2'd0;
   localparam logic [1:0] REG_RATE = 2'd1;
   localparam logic [1:0] REG_FORMAT = 2'd2;
   localparam logic [1:0] REG_MODE = 2'd3;
   localparam logic [15:0] VOLUME_RESET = 16'd16384;
   localparam logic [23:0] RATE_RESET = 24'd65536;

   typedef struct packed {
      logic [1:0] command;
      logic signed [15:0] source_left;
      logic signed [15:0] source_right;
      logic signed [15:0] bus_left;
      logic signed [15:0] bus_right;
   } req_type;

   typedef struct packed {
      logic signed [15:0] mixed_left;
      logic signed [15:0] mixed_right;
      logic applied;
      logic [15:0] mixed_total;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic stereo;
      logic [15:0] frac;
      logic [15:0] volume;
   } lane_ctl_type;
endpackage

// ----- rtl/rlms_stream_if.sv -----
// Valid/ready stream interface carrying one payload.
// Depends on nothing but the payload type parameter.
`timescale 1ns / 1ps
interface rlms_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/resample_lerp_mix_saturate_unit.sv -----
// Top level of the resample, interpolate and mix unit.
// A mix request passes the store read, the five lane stages and the output register
// before its result is offered; no new request of any kind is taken until that result
// is accepted. Loads and clears go back to back while no mix is in flight or waiting.
// Synchronous active-high reset sets volume and rate to their reset values, clears
// format, mode, count, position, counter and the valid flags; the store is not cleared.
`timescale 1ns / 1ps
module resample_lerp_mix_saturate_unit #(
   parameter int SOURCE_DEPTH = rlms_pkg::SourceDepth
) (
   input logic clock,
   input logic reset,
   rlms_stream_if.sink req,
   rlms_stream_if.source rsp,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [3:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam int AW = $clog2(SOURCE_DEPTH);
   localparam int CW = AW + 1;
   localparam int PW = CW + 16;
   localparam int Latency = 6;

   logic [15:0] volume_ff;
   logic [23:0] rate_ff;
   logic format_ff, mode_ff;
   logic [CW-1:0] count_ff;
   logic [PW-1:0] pos_ff;
   logic [15:0] total_ff;
   logic [Latency-1:0] busy_ff;
   logic applied_ff [Latency];
   logic stereo_ff [Latency];
   logic signed [15:0] busl_ff [Latency];
   logic signed [15:0] busr_ff [Latency];
   logic [15:0] frac_ff;
   logic [15:0] tot_hold_ff;
   logic rsp_valid_ff;
   rlms_pkg::rsp_type rsp_ff;

   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[3:2])
         rlms_pkg::REG_VOLUME: csr_prdata = {16'd0, volume_ff};
         rlms_pkg::REG_RATE: csr_prdata = {8'd0, rate_ff};
         rlms_pkg::REG_FORMAT: csr_prdata = {31'd0, format_ff};
         default: csr_prdata = {31'd0, mode_ff};
      endcase
   end

   logic wr;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   logic accept;
   assign req.ready = busy_ff == '0 && !rsp_valid_ff;
   assign accept = req.valid && req.ready;

   logic [15:0] lo_w, hi_w;
   always_comb begin
      lo_w = format_ff ? 16'({8'd0, req.data.source_left[7:0]} * 16'd256 - 16'd32767)
                       : req.data.source_left;
      hi_w = format_ff ? 16'({8'd0, req.data.source_right[7:0]} * 16'd256 - 16'd32767)
                       : req.data.source_right;
   end

   logic do_load, do_mix, live;
   logic [AW-1:0] idx, nxt;
   logic [CW-1:0] nxt_w;
   assign live = count_ff != '0 && pos_ff < {count_ff, 16'd0};
   assign do_load = accept && req.data.command == rlms_pkg::CMD_LOAD
                    && count_ff < CW'(SOURCE_DEPTH);
   assign do_mix = accept && req.data.command == rlms_pkg::CMD_MIX;
   always_comb begin
      nxt_w = CW'(pos_ff[PW-1:16]) + CW'(1);
      if (nxt_w > count_ff - CW'(1)) begin
         nxt_w = count_ff - CW'(1);
      end
      idx = pos_ff[PW-1:16] >= CW'(SOURCE_DEPTH) ? AW'(SOURCE_DEPTH - 1) : pos_ff[AW+15:16];
      nxt = nxt_w[AW-1:0];
   end

   logic [31:0] ea, eb;
   rlms_ram #(.Width(32), .Depth(SOURCE_DEPTH)) u_ram_a (
      .clock, .wr_en(do_load), .wr_addr(count_ff[AW-1:0]), .wr_data({hi_w, lo_w}),
      .rd_addr(idx), .rd_data(ea));
   rlms_ram #(.Width(32), .Depth(SOURCE_DEPTH)) u_ram_b (
      .clock, .wr_en(do_load), .wr_addr(count_ff[AW-1:0]), .wr_data({hi_w, lo_w}),
      .rd_addr(nxt), .rd_data(eb));

   rlms_pkg::lane_ctl_type ctl;
   assign ctl = '{valid: busy_ff[0], stereo: stereo_ff[0], frac: frac_ff, volume: volume_ff};
   logic signed [15:0] ml, mr;
   rlms_lane u_lane_l (.clock, .ctl, .sample_a(ea[15:0]), .sample_b(eb[15:0]),
      .bus(busl_ff[0]), .mixed(ml));
   rlms_lane u_lane_r (.clock, .ctl, .sample_a(ea[31:16]), .sample_b(eb[31:16]),
      .bus(busr_ff[0]), .mixed(mr));

   logic [PW:0] pos_sum;
   assign pos_sum = (PW+1)'(pos_ff) + (PW+1)'(rate_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= rlms_pkg::VOLUME_RESET;
         rate_ff <= rlms_pkg::RATE_RESET;
         format_ff <= 1'b0;
         mode_ff <= 1'b0;
         count_ff <= '0;
         pos_ff <= '0;
         total_ff <= '0;
         busy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr) begin
            unique case (csr_paddr[3:2])
               rlms_pkg::REG_VOLUME: volume_ff <= csr_pwdata[15:0];
               rlms_pkg::REG_RATE: rate_ff <= csr_pwdata[23:0];
               rlms_pkg::REG_FORMAT: format_ff <= csr_pwdata[0];
               default: mode_ff <= csr_pwdata[0];
            endcase
         end
         if (accept && req.data.command == rlms_pkg::CMD_CLEAR) begin
            count_ff <= '0;
            pos_ff <= '0;
            total_ff <= '0;
         end
         if (do_load) begin
            count_ff <= count_ff + CW'(1);
         end
         if (do_mix && live) begin
            if (total_ff != 16'hffff) begin
               total_ff <= total_ff + 16'd1;
            end
            pos_ff <= pos_sum > (PW+1)'({CW'(SOURCE_DEPTH), 16'd0})
                      ? {CW'(SOURCE_DEPTH), 16'd0} : pos_sum[PW-1:0];
         end
         busy_ff <= {busy_ff[Latency-2:0], do_mix};
         if (busy_ff[Latency-1]) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_mix) begin
         applied_ff[0] <= live;
         stereo_ff[0] <= mode_ff;
         busl_ff[0] <= req.data.bus_left;
         busr_ff[0] <= req.data.bus_right;
         frac_ff <= pos_ff[15:0];
         tot_hold_ff <= live && total_ff != 16'hffff ? total_ff + 16'd1 : total_ff;
      end
      for (int i = 1; i < Latency; i++) begin
         applied_ff[i] <= applied_ff[i-1];
         stereo_ff[i] <= stereo_ff[i-1];
         busl_ff[i] <= busl_ff[i-1];
         busr_ff[i] <= busr_ff[i-1];
      end
      if (busy_ff[Latency-1]) begin
         rsp_ff.applied <= applied_ff[Latency-1];
         rsp_ff.mixed_left <= applied_ff[Latency-1] ? ml : busl_ff[Latency-1];
         rsp_ff.mixed_right <= applied_ff[Latency-1] && stereo_ff[Latency-1]
                               ? mr : busr_ff[Latency-1];
         rsp_ff.mixed_total <= tot_hold_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;
endmodule

// ----- rtl/rlms_ram.sv -----
// Generic single-port write, single-port registered read RAM.
// No dependencies.
`timescale 1ns / 1ps
module rlms_ram #(
   parameter int Width = 32,
   parameter int Depth = 4096
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(Depth)-1:0] wr_addr,
   input logic [Width-1:0] wr_data,
   input logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/rlms_lane.sv -----
// One channel lane: interpolation, volume scaling and saturating mix.
// Depends on rlms_pkg. Five register stages; three of them each hold a multiply.
`timescale 1ns / 1ps
module rlms_lane (
   input logic clock,
   input rlms_pkg::lane_ctl_type ctl,
   input logic signed [15:0] sample_a,
   input logic signed [15:0] sample_b,
   input logic signed [15:0] bus,
   output logic signed [15:0] mixed
);
   logic signed [16:0] diff_ff;
   logic signed [15:0] a_ff, bus1_ff, bus2_ff, bus3_ff;
   logic [15:0] frac_ff, vol1_ff, vol2_ff;
   logic signed [32:0] l_ff;
   logic signed [49:0] s_ff;
   logic signed [66:0] p_ff;
   logic signed [33:0] s_q;
   logic signed [20:0] r_in;
   logic signed [66:0] q_in;

   always_ff @(posedge clock) begin
      diff_ff <= 17'(sample_b) - 17'(sample_a);
      a_ff <= sample_a;
      frac_ff <= ctl.frac;
      vol1_ff <= ctl.volume;
      bus1_ff <= bus;
      l_ff <= (33'(a_ff) <<< 16) + 33'(diff_ff * $signed({1'b0, frac_ff}));
      vol2_ff <= vol1_ff;
      bus2_ff <= bus1_ff;
      s_ff <= 50'(l_ff * $signed({1'b0, vol2_ff}));
      bus3_ff <= bus2_ff;
      p_ff <= 67'($signed(17'sd32767 - 17'(bus3_ff)) * s_q);
      mixed <= r_in > 21'sd32767 ? 16'sh7fff
               : (r_in < -21'sd32768 ? 16'sh8000 : r_in[15:0]);
   end

   // Truncating division toward zero by 65536.
   assign s_q = 34'((s_ff + (s_ff < 0 ? 50'sd65535 : 50'sd0)) >>> 16);

   logic signed [15:0] bus4_ff;
   always_ff @(posedge clock) begin
      bus4_ff <= bus3_ff;
   end

   // Division by 32767*16384: a shift by 14, then a shift-and-add estimate of the
   // quotient by 32767 that is at most two short, corrected from the remainder.
   logic [48:0] mag;
   logic [48:0] num;
   logic [48:0] quo;
   logic [48:0] rem;
   always_comb begin
      mag = p_ff < 0 ? 49'(-p_ff) : 49'(p_ff);
      num = mag >> 14;
      quo = (num >> 15) + (num >> 30);
      rem = num - ((quo << 15) - quo);
      if (rem >= 49'd65534) begin
         quo = quo + 49'd2;
      end else if (rem >= 49'd32767) begin
         quo = quo + 49'd1;
      end
      q_in = p_ff < 0 ? -67'(quo) : 67'(quo);
      r_in = 21'(q_in) + 21'(bus4_ff);
   end

   logic unused;
   assign unused = ctl.valid ^ ctl.stereo;
endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the resample, interpolate and mix unit.
// Drives requests and register writes, predicts every mixed result and checks it.
// Depends on rlms_pkg, rlms_stream_if and resample_lerp_mix_saturate_unit.
`timescale 1ns / 1ps
module tb;
   localparam int IdleLimit = 5000;
   localparam int DrainCycles = 12;
   localparam int Phases = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   rlms_stream_if #(.payload_type(rlms_pkg::req_type)) req_if (clock);
   rlms_stream_if #(.payload_type(rlms_pkg::rsp_type)) rsp_if (clock);

   resample_lerp_mix_saturate_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // Predictor state.
   logic signed [15:0] left_store [rlms_pkg::SourceDepth];
   logic signed [15:0] right_store [rlms_pkg::SourceDepth];
   int unsigned loaded_count;
   longint unsigned play_position;
   int unsigned mix_total;
   logic [15:0] gain;
   logic [23:0] rate;
   logic eight_bit;
   logic stereo;

   rlms_pkg::rsp_type pending_mixes [$];
   int errors = 0;
   int idle_cycles = 0;
   bit hold_request = 1'b0;
   int hold_cycles = 0;
   int burst_left = 0;

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic logic signed [15:0] widen_sample(logic [15:0] raw);
      int v;
      if (eight_bit) begin
         v = int'(raw[7:0]) * 256 - 32767;
      end else begin
         v = int'($signed(raw));
      end
      return v[15:0];
   endfunction

   function automatic logic signed [15:0] blend(int a, int b, longint frac, int bus);
      longint l, s, q, r;
      l = longint'(a) * 65536 + longint'(b - a) * frac;
      s = (l * longint'(gain)) / 65536;
      q = (longint'(32767 - bus) * s) / (longint'(32767) * 16384);
      r = q + bus;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic void predict_request(rlms_pkg::req_type r);
      rlms_pkg::rsp_type e;
      int idx, nxt;
      longint frac;
      case (r.command)
         rlms_pkg::CMD_CLEAR: begin
            loaded_count = 0;
            play_position = 0;
            mix_total = 0;
         end
         rlms_pkg::CMD_LOAD: begin
            if (loaded_count < rlms_pkg::SourceDepth) begin
               left_store[loaded_count] = widen_sample(r.source_left);
               right_store[loaded_count] = widen_sample(r.source_right);
               loaded_count++;
            end
         end
         rlms_pkg::CMD_MIX: begin
            e.mixed_left = r.bus_left;
            e.mixed_right = r.bus_right;
            e.applied = 1'b0;
            if (loaded_count > 0 && play_position < (longint'(loaded_count) << 16)) begin
               idx = int'(play_position >> 16);
               frac = longint'(play_position & 64'hFFFF);
               nxt = idx + 1;
               if (nxt > int'(loaded_count) - 1) nxt = loaded_count - 1;
               if (idx >= rlms_pkg::SourceDepth) idx = rlms_pkg::SourceDepth - 1;
               e.mixed_left = blend(left_store[idx], left_store[nxt], frac, r.bus_left);
               if (stereo) begin
                  e.mixed_right = blend(right_store[idx], right_store[nxt], frac,
                     r.bus_right);
               end
               e.applied = 1'b1;
               if (mix_total < 65535) mix_total++;
               play_position += rate;
               if (play_position > (longint'(rlms_pkg::SourceDepth) << 16)) begin
                  play_position = longint'(rlms_pkg::SourceDepth) << 16;
               end
            end
            e.mixed_total = mix_total[15:0];
            pending_mixes.push_back(e);
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_request(logic [1:0] cmd, logic [15:0] sl, logic [15:0] sr,
         logic [15:0] bl, logic [15:0] br);
      rlms_pkg::req_type r;
      int gap;
      r.command = cmd;
      r.source_left = sl;
      r.source_right = sr;
      r.bus_left = bl;
      r.bus_right = br;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_if.valid = 1'b1;
      req_if.data = r;
      do @(posedge clock); while (!req_if.ready);
      predict_request(r);
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   task automatic send_random(logic [1:0] cmd);
      send_request(cmd, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic wait_idle();
      req_if.valid = 1'b0;
      while (pending_mixes.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [31:0] value);
      wait_idle();
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {index, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      case (index)
         rlms_pkg::REG_VOLUME: gain = value[15:0];
         rlms_pkg::REG_RATE: rate = value[23:0];
         rlms_pkg::REG_FORMAT: eight_bit = value[0];
         rlms_pkg::REG_MODE: stereo = value[0];
         default: begin
         end
      endcase
   endtask

   task automatic set_all(logic [15:0] g, logic [23:0] r, logic f, logic m);
      write_register(rlms_pkg::REG_VOLUME, 32'(g));
      write_register(rlms_pkg::REG_RATE, 32'(r));
      write_register(rlms_pkg::REG_FORMAT, 32'(f));
      write_register(rlms_pkg::REG_MODE, 32'(m));
   endtask

   task automatic test_directed();
      send_random(rlms_pkg::CMD_MIX);
      send_request(rlms_pkg::CMD_LOAD, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000);
      send_request(rlms_pkg::CMD_LOAD, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
      send_request(rlms_pkg::CMD_LOAD, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
      send_request(rlms_pkg::CMD_MIX, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
      send_request(rlms_pkg::CMD_MIX, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
      send_random(rlms_pkg::CMD_NONE);
      send_request(rlms_pkg::CMD_MIX, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      send_request(rlms_pkg::CMD_MIX, 16'h0000, 16'h0000, 16'h1234, 16'h4321);
      set_all(16'hFFFF, 24'h008000, 1'b0, 1'b1);
      send_request(rlms_pkg::CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_request(rlms_pkg::CMD_LOAD, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
      send_request(rlms_pkg::CMD_LOAD, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000);
      repeat (5) send_request(rlms_pkg::CMD_MIX, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
      set_all(16'h0000, 24'hFFFFFF, 1'b1, 1'b1);
      send_request(rlms_pkg::CMD_LOAD, 16'hFF00, 16'h00FF, 16'h0000, 16'h0000);
      send_request(rlms_pkg::CMD_LOAD, 16'h00FF, 16'hFF00, 16'h0000, 16'h0000);
      send_request(rlms_pkg::CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_request(rlms_pkg::CMD_LOAD, 16'h5AFF, 16'hA500, 16'h0000, 16'h0000);
      send_random(rlms_pkg::CMD_MIX);
      send_random(rlms_pkg::CMD_MIX);
   endtask

   task automatic test_random_phases();
      int n;
      for (int phase = 0; phase < Phases; phase++) begin
         case ($urandom_range(0, 3))
            0: set_all(16'hFFFF, 24'hFFFFFF, 1'($urandom), 1'($urandom));
            1: set_all(16'h0000, 24'h000000, 1'($urandom), 1'($urandom));
            default: set_all(16'($urandom), $urandom_range(0, 3) == 0 ?
               24'($urandom) : 24'($urandom_range(1, 131072)), 1'($urandom),
               1'($urandom));
         endcase
         send_random(rlms_pkg::CMD_CLEAR);
         n = $urandom_range(1, 12);
         repeat (n) send_random(rlms_pkg::CMD_LOAD);
         n = $urandom_range(8, 20);
         repeat (n) begin
            case ($urandom_range(0, 19))
               0: send_random(rlms_pkg::CMD_NONE);
               1: send_random(rlms_pkg::CMD_LOAD);
               2: send_random(rlms_pkg::CMD_CLEAR);
               default: send_random(rlms_pkg::CMD_MIX);
            endcase
         end
      end
   endtask

   task automatic test_backpressure();
      write_register(rlms_pkg::REG_RATE, 32'h00004000);
      send_random(rlms_pkg::CMD_CLEAR);
      repeat (3) send_random(rlms_pkg::CMD_LOAD);
      hold_request = 1'b1;
      repeat (30) send_random(rlms_pkg::CMD_MIX);
   endtask

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_cycles = 300;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_if.ready <= 1'b0;
      end else if (($time / 640) % 3 == 0) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 2) != 0);
      end
   end

   always @(posedge clock) begin
      rlms_pkg::rsp_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_mixes.size() == 0) begin
            $error("unexpected result %p", rsp_if.data);
            errors++;
         end else begin
            e = pending_mixes.pop_front();
            if (rsp_if.data.mixed_left !== e.mixed_left) begin
               $error("mixed_left expected %0d actual %0d", e.mixed_left,
                  rsp_if.data.mixed_left);
               errors++;
            end
            if (rsp_if.data.mixed_right !== e.mixed_right) begin
               $error("mixed_right expected %0d actual %0d", e.mixed_right,
                  rsp_if.data.mixed_right);
               errors++;
            end
            if (rsp_if.data.applied !== e.applied) begin
               $error("applied expected %0d actual %0d", e.applied, rsp_if.data.applied);
               errors++;
            end
            if (rsp_if.data.mixed_total !== e.mixed_total) begin
               $error("mixed_total expected %0d actual %0d", e.mixed_total,
                  rsp_if.data.mixed_total);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > IdleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      loaded_count = 0;
      play_position = 0;
      mix_total = 0;
      gain = rlms_pkg::VOLUME_RESET;
      rate = rlms_pkg::RATE_RESET;
      eight_bit = 1'b0;
      stereo = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_phases();
      test_backpressure();
      test_random_phases();
      wait_idle();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
